### sv/sir_pkg.sv
package sir_pkg;

  localparam int ID_W    = 16;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 4;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int PIDX_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN   = 3'd0,
    CMD_DESPAWN = 3'd1,
    CMD_FIND    = 3'd2,
    CMD_LOCAL   = 3'd3,
    CMD_PAIR    = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK             = 4'd0,
    STAT_FULL           = 4'd1,
    STAT_BAD_ID         = 4'd2,
    STAT_RETIRED        = 4'd3,
    STAT_DUPLICATE      = 4'd4,
    STAT_LOCAL_TAKEN    = 4'd5,
    STAT_SETUP_REJECTED = 4'd6,
    STAT_NOT_FOUND      = 4'd7,
    STAT_BAD_PAIR       = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] key;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_APPLY,
    S_PAIR,
    S_DONE
  } fsm_t;

endpackage

### sv/sir_cell.sv
module sir_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  sir_pkg::cell_ctl_t      ctl,
  input  logic [sir_pkg::ID_W-1:0] left_val,
  input  logic                    left_valid,
  input  logic                    left_lt,
  input  logic [sir_pkg::ID_W-1:0] right_val,
  input  logic                    right_valid,
  output logic [sir_pkg::ID_W-1:0] val,
  output logic                    valid,
  output logic                    lt,
  output logic                    eq
);
  import sir_pkg::*;

  assign lt = valid && (val < ctl.key);
  assign eq = valid && (val == ctl.key);

  // insert: the first cell not below the key takes it, later cells take the left neighbor
  // remove: every cell not below the key takes the right neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_INSERT: begin
          if (!lt) begin
            valid <= left_lt ? 1'b1 : left_valid;
          end
        end
        OP_REMOVE: begin
          if (!lt) begin
            valid <= right_valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_INSERT: begin
        if (!lt) begin
          val <= left_lt ? ctl.key : left_val;
        end
      end
      OP_REMOVE: begin
        if (!lt) begin
          val <= right_val;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/sorted_id_roster.sv
// Sorted id roster: a row of MAX_ENTRIES cells holds entrant ids in ascending order. Every
// cell compares its id against a broadcast key in parallel; the controller then walks the
// resulting flags one slot per cycle to find the sorted position, and an insert or removal
// moves every cell from that position up by one neighbor at once. Spawn, despawn, find and
// local query wait for that flag walk to reach the sorted position before they are applied.
// Pair unranking steps one triangle row per cycle, and unused command codes go straight to
// the result. One command is in flight at a time; the result sits in an output register so
// a new command can be taken while it waits to be transferred.
module sorted_id_roster #(
  parameter int MAX_ENTRIES = 16,
  parameter int ID_LIMIT    = 65534
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sir_pkg::CMD_W-1:0]   command,
  input  logic [sir_pkg::ID_W-1:0]    entrant_id,
  input  logic                        local_player,
  input  logic                        setup_ok,
  input  logic [sir_pkg::PIDX_W-1:0]  pair_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        success,
  output logic [sir_pkg::STAT_W-1:0]  status,
  output logic [sir_pkg::ID_W-1:0]    result_id,
  output logic [sir_pkg::SLOT_W-1:0]  slot,
  output logic [sir_pkg::SLOT_W-1:0]  first_slot,
  output logic [sir_pkg::SLOT_W-1:0]  second_slot,
  output logic [sir_pkg::COUNT_W-1:0] entrant_count
);
  import sir_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SW    = (CNT_W + 1 > PIDX_W) ? CNT_W + 1 : PIDX_W;

  fsm_t state, state_next;

  cmd_t              cmd_r;
  logic [ID_W-1:0]   key;
  logic              want_local;
  logic              setup_r;
  logic [PIDX_W-1:0] rem;
  logic [CNT_W-1:0]  a_cnt;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  count;
  logic [ID_W-1:0]   next_auto_id;
  logic [ID_W-1:0]   retire_floor;
  logic [ID_W-1:0]   local_id;
  logic [MAX_ENTRIES-1:0] lt_sh, eq_sh;

  logic              res_success;
  status_t           res_status;
  logic [ID_W-1:0]   res_id;
  logic [SW-1:0]     res_slot, res_first, res_second;

  cell_ctl_t         ctl;
  logic [ID_W-1:0]   cell_val   [MAX_ENTRIES];
  logic              cell_valid [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] lt_vec, eq_vec;

  logic              in_go, out_free;
  status_t           spawn_status;
  logic              found;
  logic [SW-1:0]     n_w, a_w, rem_w, row_w;
  logic              pair_end, pair_hit;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      logic [ID_W-1:0] lv, rv;
      logic            lvalid, llt, rvalid;
      if (gi == 0) begin : g_head
        assign lv     = '0;
        assign lvalid = 1'b0;
        assign llt    = 1'b1;
      end else begin : g_mid
        assign lv     = cell_val[gi-1];
        assign lvalid = cell_valid[gi-1];
        assign llt    = lt_vec[gi-1];
      end
      if (gi == MAX_ENTRIES - 1) begin : g_tail
        assign rv     = '0;
        assign rvalid = 1'b0;
      end else begin : g_body
        assign rv     = cell_val[gi+1];
        assign rvalid = cell_valid[gi+1];
      end
      sir_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .left_val    (lv),
        .left_valid  (lvalid),
        .left_lt     (llt),
        .right_val   (rv),
        .right_valid (rvalid),
        .val         (cell_val[gi]),
        .valid       (cell_valid[gi]),
        .lt          (lt_vec[gi]),
        .eq          (eq_vec[gi])
      );
    end
  endgenerate

  assign in_go    = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign found    = eq_sh[0];

  assign n_w      = SW'(count);
  assign a_w      = SW'(a_cnt);
  assign rem_w    = SW'(rem);
  assign row_w    = n_w - a_w - SW'(1);
  assign pair_end = (a_w + SW'(1)) >= n_w;
  assign pair_hit = !pair_end && (rem_w < row_w);

  always_comb begin
    if (count >= CNT_W'(MAX_ENTRIES)) begin
      spawn_status = STAT_FULL;
    end else if (key == '0 || key > ID_W'(ID_LIMIT)) begin
      spawn_status = STAT_BAD_ID;
    end else if (key < retire_floor) begin
      spawn_status = STAT_RETIRED;
    end else if (found) begin
      spawn_status = STAT_DUPLICATE;
    end else if (want_local && local_id != '0) begin
      spawn_status = STAT_LOCAL_TAKEN;
    end else if (!setup_r) begin
      spawn_status = STAT_SETUP_REJECTED;
    end else begin
      spawn_status = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != S_IDLE);
    ctl.op     = OP_HOLD;
    ctl.key    = key;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (command == CMD_PAIR) begin
            state_next = S_PAIR;
          end else if (command <= CMD_LOCAL) begin
            state_next = S_LOAD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_LOAD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!lt_sh[0]) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        state_next = S_DONE;
        if (cmd_r == CMD_SPAWN && spawn_status == STAT_OK) begin
          ctl.op = OP_INSERT;
        end else if (cmd_r == CMD_DESPAWN && found) begin
          ctl.op = OP_REMOVE;
        end
      end
      S_PAIR: begin
        if (pair_hit || pair_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // roster state
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      next_auto_id <= ID_W'(1);
      retire_floor <= ID_W'(1);
      local_id     <= '0;
    end else if (state == S_APPLY) begin
      if (cmd_r == CMD_SPAWN && spawn_status == STAT_OK) begin
        count <= count + CNT_W'(1);
        if (key >= next_auto_id) begin
          next_auto_id <= key + ID_W'(1);
        end
        if (want_local) begin
          local_id <= key;
        end
      end else if (cmd_r == CMD_DESPAWN && found) begin
        count <= count - CNT_W'(1);
        if (key >= retire_floor) begin
          retire_floor <= key + ID_W'(1);
        end
        if (local_id == key) begin
          local_id <= '0;
        end
      end
    end
  end

  // command datapath
  always_ff @(posedge clk) begin
    if (in_go) begin
      cmd_r      <= cmd_t'(command);
      want_local <= local_player;
      setup_r    <= setup_ok;
      rem        <= pair_index;
      a_cnt      <= '0;
      if (command == CMD_SPAWN) begin
        key <= (entrant_id != '0) ? entrant_id : next_auto_id;
      end else if (command == CMD_LOCAL) begin
        key <= local_id;
      end else begin
        key <= entrant_id;
      end
      res_success <= 1'b0;
      res_status  <= STAT_OK;
      res_id      <= '0;
      res_slot    <= '0;
      res_first   <= '0;
      res_second  <= '0;
    end
    unique case (state)
      S_LOAD: begin
        lt_sh <= lt_vec;
        eq_sh <= eq_vec;
        pos   <= '0;
      end
      S_SCAN: begin
        if (lt_sh[0]) begin
          lt_sh <= lt_sh >> 1;
          eq_sh <= eq_sh >> 1;
          pos   <= pos + CNT_W'(1);
        end
      end
      S_APPLY: begin
        unique case (cmd_r)
          CMD_SPAWN: begin
            res_status <= spawn_status;
            if (spawn_status == STAT_OK) begin
              res_success <= 1'b1;
              res_id      <= key;
              res_slot    <= SW'(pos);
            end
          end
          CMD_DESPAWN, CMD_FIND: begin
            if (found) begin
              res_success <= 1'b1;
              res_slot    <= SW'(pos);
            end else begin
              res_status <= STAT_NOT_FOUND;
            end
          end
          CMD_LOCAL: begin
            res_id <= key;
            if (found) begin
              res_success <= 1'b1;
              res_slot    <= SW'(pos);
            end else begin
              res_status <= STAT_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
      end
      S_PAIR: begin
        if (pair_hit) begin
          res_success <= 1'b1;
          res_first   <= a_w;
          res_second  <= a_w + SW'(1) + rem_w;
        end else if (pair_end) begin
          res_status <= STAT_BAD_PAIR;
        end else begin
          rem   <= PIDX_W'(rem_w - row_w);
          a_cnt <= a_cnt + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      success       <= res_success;
      status        <= res_status;
      result_id     <= res_id;
      slot          <= res_slot[SLOT_W-1:0];
      first_slot    <= res_first[SLOT_W-1:0];
      second_slot   <= res_second[SLOT_W-1:0];
      entrant_count <= n_w[COUNT_W-1:0];
    end
  end

endmodule

### tb/sv/sorted_id_roster_tb.sv
`timescale 1ns / 1ps

module sorted_id_roster_tb;
  import sir_pkg::*;

  localparam int MAX_ENTRIES = 16;
  localparam int ID_LIMIT    = 65534;

  localparam logic [CMD_W-1:0] CMD_RESERVED     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESERVED_TOP = 3'd7;

  localparam int PHASE_ITEMS     = 270;
  localparam int SWING_ITEMS     = 120;
  localparam int PHASE_IDLE  [4] = '{0, 65, 0, 22};
  localparam int PHASE_STALL [4] = '{0, 0, 65, 22};

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic              local_player;
    logic              setup_ok;
    logic [PIDX_W-1:0] pair_index;
  } roster_cmd_t;

  typedef struct packed {
    logic               success;
    status_t            status;
    logic [ID_W-1:0]    result_id;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  first_slot;
    logic [SLOT_W-1:0]  second_slot;
    logic [COUNT_W-1:0] count;
  } roster_result_t;

  typedef struct packed {
    roster_cmd_t    c;
    logic           typed;
    roster_result_t r;
  } roster_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    command = '0;
  logic [ID_W-1:0]     entrant_id = '0;
  logic                local_player = 1'b0;
  logic                setup_ok = 1'b0;
  logic [PIDX_W-1:0]   pair_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                success;
  logic [STAT_W-1:0]   status;
  logic [ID_W-1:0]     result_id;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   first_slot;
  logic [SLOT_W-1:0]   second_slot;
  logic [COUNT_W-1:0]  entrant_count;

  // predicted roster contents
  logic [ID_W-1:0] roster_ids [MAX_ENTRIES];
  int              roster_count = 0;
  int unsigned     cursor_id = 1;
  int unsigned     floor_id = 1;
  int unsigned     local_held = 0;

  roster_result_t pending_results [$];
  int             mismatches = 0;
  int             results_seen = 0;
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             cmd_seen [8];
  int             status_seen [16];

  roster_row_t head_rows [21] = '{
    '{'{CMD_LOCAL, 16'd0, 1'b0, 1'b1, 8'd0}, 1'b1,
      '{1'b0, STAT_NOT_FOUND, 16'd0, 4'd0, 4'd0, 4'd0, 5'd0}},
    '{'{CMD_FIND, 16'd0, 1'b0, 1'b1, 8'd0}, 1'b1,
      '{1'b0, STAT_NOT_FOUND, 16'd0, 4'd0, 4'd0, 4'd0, 5'd0}},
    '{'{CMD_DESPAWN, 16'd5, 1'b0, 1'b1, 8'd0}, 1'b1,
      '{1'b0, STAT_NOT_FOUND, 16'd0, 4'd0, 4'd0, 4'd0, 5'd0}},
    '{'{CMD_PAIR, 16'd0, 1'b0, 1'b1, 8'd255}, 1'b1,
      '{1'b0, STAT_BAD_PAIR, 16'd0, 4'd0, 4'd0, 4'd0, 5'd0}},
    '{'{CMD_SPAWN, 16'd0, 1'b1, 1'b1, 8'd0}, 1'b1,
      '{1'b1, STAT_OK, 16'd1, 4'd0, 4'd0, 4'd0, 5'd1}},
    '{'{CMD_SPAWN, 16'd65535, 1'b0, 1'b1, 8'd0}, 1'b1,
      '{1'b0, STAT_BAD_ID, 16'd0, 4'd0, 4'd0, 4'd0, 5'd1}},
    '{'{CMD_SPAWN, 16'd1, 1'b0, 1'b1, 8'd0}, 1'b1,
      '{1'b0, STAT_DUPLICATE, 16'd0, 4'd0, 4'd0, 4'd0, 5'd1}},
    '{'{CMD_SPAWN, 16'd100, 1'b1, 1'b1, 8'd0}, 1'b1,
      '{1'b0, STAT_LOCAL_TAKEN, 16'd0, 4'd0, 4'd0, 4'd0, 5'd1}},
    '{'{CMD_SPAWN, 16'd100, 1'b0, 1'b0, 8'd0}, 1'b1,
      '{1'b0, STAT_SETUP_REJECTED, 16'd0, 4'd0, 4'd0, 4'd0, 5'd1}},
    '{'{CMD_SPAWN, 16'd100, 1'b0, 1'b1, 8'd0}, 1'b1,
      '{1'b1, STAT_OK, 16'd100, 4'd1, 4'd0, 4'd0, 5'd2}},
    '{'{CMD_SPAWN, 16'd50, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_SPAWN, 16'd0, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_PAIR, 16'd0, 1'b0, 1'b1, 8'd5}, 1'b0, '0},
    '{'{CMD_PAIR, 16'd0, 1'b0, 1'b1, 8'd6}, 1'b1,
      '{1'b0, STAT_BAD_PAIR, 16'd0, 4'd0, 4'd0, 4'd0, 5'd4}},
    '{'{CMD_FIND, 16'd100, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_LOCAL, 16'd0, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_DESPAWN, 16'd1, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_SPAWN, 16'd1, 1'b0, 1'b1, 8'd0}, 1'b1,
      '{1'b0, STAT_RETIRED, 16'd0, 4'd0, 4'd0, 4'd0, 5'd3}},
    '{'{CMD_RESERVED, 16'd0, 1'b0, 1'b0, 8'd0}, 1'b1,
      '{1'b0, STAT_OK, 16'd0, 4'd0, 4'd0, 4'd0, 5'd3}},
    '{'{CMD_RESERVED_TOP, 16'd65535, 1'b1, 1'b1, 8'd255}, 1'b1,
      '{1'b0, STAT_OK, 16'd0, 4'd0, 4'd0, 4'd0, 5'd3}},
    '{'{CMD_FIND, 16'd65535, 1'b1, 1'b0, 8'd255}, 1'b1,
      '{1'b0, STAT_NOT_FOUND, 16'd0, 4'd0, 4'd0, 4'd0, 5'd3}}
  };

  // runs after the roster has been emptied, pushes the cursor past the id limit
  roster_row_t tail_rows [10] = '{
    '{'{CMD_SPAWN, 16'd65534, 1'b1, 1'b1, 8'd0}, 1'b1,
      '{1'b1, STAT_OK, 16'd65534, 4'd0, 4'd0, 4'd0, 5'd1}},
    '{'{CMD_SPAWN, 16'd0, 1'b0, 1'b1, 8'd0}, 1'b1,
      '{1'b0, STAT_BAD_ID, 16'd0, 4'd0, 4'd0, 4'd0, 5'd1}},
    '{'{CMD_SPAWN, 16'd65533, 1'b1, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_SPAWN, 16'd65533, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_PAIR, 16'd0, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_LOCAL, 16'd0, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_DESPAWN, 16'd65534, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_SPAWN, 16'd65534, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_FIND, 16'd65533, 1'b0, 1'b1, 8'd0}, 1'b0, '0},
    '{'{CMD_PAIR, 16'd0, 1'b0, 1'b1, 8'd255}, 1'b0, '0}
  };

  sorted_id_roster #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .ID_LIMIT   (ID_LIMIT)
  ) uut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int roster_slot_of(int unsigned id);
    if (id == 0) return -1;
    for (int i = 0; i < roster_count; i++)
      if (roster_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic roster_result_t roster_apply(roster_cmd_t c);
    roster_result_t r;
    int unsigned    want;
    int             pos;
    int             pairs;
    int             rem;
    int             row;
    r = '0;
    r.status = STAT_OK;
    case (c.cmd)
      CMD_SPAWN: begin
        want = (c.id != 0) ? c.id : cursor_id;
        if (roster_count >= MAX_ENTRIES) r.status = STAT_FULL;
        else if (want == 0 || want > ID_LIMIT) r.status = STAT_BAD_ID;
        else if (want < floor_id) r.status = STAT_RETIRED;
        else if (roster_slot_of(want) >= 0) r.status = STAT_DUPLICATE;
        else if (c.local_player && local_held != 0) r.status = STAT_LOCAL_TAKEN;
        else if (!c.setup_ok) r.status = STAT_SETUP_REJECTED;
        else begin
          pos = roster_count;
          for (int i = 0; i < roster_count; i++)
            if (roster_ids[i] > want && pos == roster_count) pos = i;
          for (int i = roster_count; i > pos; i--) roster_ids[i] = roster_ids[i-1];
          roster_ids[pos] = ID_W'(want);
          roster_count++;
          if (want >= cursor_id) cursor_id = want + 1;
          if (c.local_player) local_held = want;
          r.success = 1'b1;
          r.result_id = ID_W'(want);
          r.slot = SLOT_W'(pos);
        end
      end
      CMD_DESPAWN: begin
        pos = roster_slot_of(c.id);
        if (pos < 0) r.status = STAT_NOT_FOUND;
        else begin
          for (int i = pos; i + 1 < roster_count; i++) roster_ids[i] = roster_ids[i+1];
          roster_count--;
          roster_ids[roster_count] = '0;
          if (c.id >= floor_id) floor_id = c.id + 1;
          if (local_held == c.id) local_held = 0;
          r.success = 1'b1;
          r.slot = SLOT_W'(pos);
        end
      end
      CMD_FIND: begin
        pos = roster_slot_of(c.id);
        if (pos < 0) r.status = STAT_NOT_FOUND;
        else begin
          r.success = 1'b1;
          r.slot = SLOT_W'(pos);
        end
      end
      CMD_LOCAL: begin
        r.result_id = ID_W'(local_held);
        pos = roster_slot_of(local_held);
        if (pos < 0) r.status = STAT_NOT_FOUND;
        else begin
          r.success = 1'b1;
          r.slot = SLOT_W'(pos);
        end
      end
      CMD_PAIR: begin
        pairs = (roster_count < 2) ? 0 : roster_count * (roster_count - 1) / 2;
        if (int'(c.pair_index) >= pairs) r.status = STAT_BAD_PAIR;
        else begin
          rem = c.pair_index;
          for (int a = 0; a + 1 < roster_count; a++) begin
            row = roster_count - 1 - a;
            if (!r.success) begin
              if (rem < row) begin
                r.first_slot = SLOT_W'(a);
                r.second_slot = SLOT_W'(a + 1 + rem);
                r.success = 1'b1;
              end else begin
                rem -= row;
              end
            end
          end
          if (!r.success) r.status = STAT_BAD_PAIR;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(roster_count);
    return r;
  endfunction

  function automatic logic [ID_W-1:0] any_held_id();
    if (roster_count > 0) return roster_ids[$urandom_range(0, roster_count - 1)];
    return ID_W'($urandom);
  endfunction

  // mostly well-formed traffic around the live roster, with some noise
  function automatic roster_cmd_t make_roster_cmd(bit drain);
    roster_cmd_t c;
    int          pick;
    int          sub;
    int          spawn_w;
    int          despawn_w;
    int unsigned near;
    int          pairs;
    c.cmd = CMD_SPAWN;
    c.id = ID_W'($urandom);
    c.local_player = ($urandom_range(0, 99) < 15);
    c.setup_ok = ($urandom_range(0, 99) < 92);
    c.pair_index = PIDX_W'($urandom);
    spawn_w = drain ? 22 : 48;
    despawn_w = drain ? 41 : 15;
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 99);
    if (pick < spawn_w) begin
      if (sub < 30) c.id = '0;
      else if (sub < 65) begin
        near = floor_id + $urandom_range(0, 40);
        c.id = (near > 65535) ? 16'hffff : ID_W'(near);
      end else if (sub < 75) c.id = any_held_id();
      else if (sub < 83) c.id = (floor_id > 1) ? ID_W'($urandom_range(1, floor_id - 1)) : '0;
      else c.setup_ok = 1'b0;
    end else if (pick < spawn_w + despawn_w) begin
      c.cmd = CMD_DESPAWN;
      if (sub < 75) c.id = any_held_id();
      else if (sub < 80) c.id = '0;
    end else if (pick < spawn_w + despawn_w + 14) begin
      c.cmd = CMD_FIND;
      if (sub < 70) c.id = any_held_id();
    end else if (pick < spawn_w + despawn_w + 22) begin
      c.cmd = CMD_LOCAL;
    end else if (pick < spawn_w + despawn_w + 35) begin
      c.cmd = CMD_PAIR;
      pairs = (roster_count < 2) ? 0 : roster_count * (roster_count - 1) / 2;
      if (sub < 85) c.pair_index = PIDX_W'($urandom_range(0, pairs + 2));
    end else begin
      c.cmd = CMD_RESERVED + CMD_W'($urandom_range(0, 2));
    end
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_cmd(roster_cmd_t c, logic typed, roster_result_t typed_r);
    roster_result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    command <= c.cmd;
    entrant_id <= c.id;
    local_player <= c.local_player;
    setup_ok <= c.setup_ok;
    pair_index <= c.pair_index;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = roster_apply(c);
    pending_results.push_back(typed ? typed_r : r);
    cmd_seen[c.cmd]++;
    @(negedge clk);
  endtask

  task automatic report_mismatch(string field, int got, int want_v);
    mismatches++;
    if (mismatches <= 40)
      $display("result %0d: %s is %0d, predicted %0d", results_seen, field, got, want_v);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    roster_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, status", int'(status), -1);
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (success !== want.success) report_mismatch("success", success, want.success);
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (result_id !== want.result_id)
          report_mismatch("result_id", result_id, want.result_id);
        if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
        if (first_slot !== want.first_slot)
          report_mismatch("first_slot", first_slot, want.first_slot);
        if (second_slot !== want.second_slot)
          report_mismatch("second_slot", second_slot, want.second_slot);
        if (entrant_count !== want.count)
          report_mismatch("entrant_count", entrant_count, want.count);
      end
    end
  end

  initial begin
    roster_cmd_t c;
    int          done_items;
    foreach (roster_ids[i]) roster_ids[i] = '0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (head_rows[i]) send_cmd(head_rows[i].c, head_rows[i].typed, head_rows[i].r);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = PHASE_IDLE[ph];
      stall_pct = PHASE_STALL[ph];
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        c = make_roster_cmd(((done_items / SWING_ITEMS) % 2) == 1);
        send_cmd(c, 1'b0, '0);
        if (c.cmd <= CMD_PAIR) done_items++;
      end
    end

    // empty the roster so the closing rows start from a known count
    while (roster_count > 0) begin
      c = '{CMD_DESPAWN, roster_ids[0], 1'b0, 1'b1, 8'd0};
      send_cmd(c, 1'b0, '0);
    end
    foreach (tail_rows[i]) send_cmd(tail_rows[i].c, tail_rows[i].typed, tail_rows[i].r);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("transfers: %0d spawn, %0d despawn, %0d find, %0d local, %0d pair, %0d unused",
             cmd_seen[CMD_SPAWN], cmd_seen[CMD_DESPAWN], cmd_seen[CMD_FIND],
             cmd_seen[CMD_LOCAL], cmd_seen[CMD_PAIR],
             cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
    $display("%0d results checked; rejects: %0d full, %0d retired, %0d dup, %0d local taken",
             results_seen, status_seen[STAT_FULL], status_seen[STAT_RETIRED],
             status_seen[STAT_DUPLICATE], status_seen[STAT_LOCAL_TAKEN]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
sv/sir_pkg.sv
sv/sir_cell.sv
sv/sorted_id_roster.sv
tb/sv/sorted_id_roster_tb.sv
